>>> rtl/stacg_pkg.sv
// shared types, codes and translation function for the stack-code translator
package stacg_pkg;

  localparam logic [1:0] CS_NIL  = 2'd0;
  localparam logic [1:0] CS_AD   = 2'd1;
  localparam logic [1:0] CS_AC   = 2'd2;
  localparam logic [1:0] CS_ACAD = 2'd3;

  localparam logic [3:0] FN_L = 4'd0;
  localparam logic [3:0] FN_S = 4'd1;
  localparam logic [3:0] FN_A = 4'd2;
  localparam logic [3:0] FN_J = 4'd3;
  localparam logic [3:0] FN_T = 4'd4;
  localparam logic [3:0] FN_F = 4'd5;
  localparam logic [3:0] FN_K = 4'd6;
  localparam logic [3:0] FN_X = 4'd7;
  localparam logic [3:0] FN_D = 4'd8;

  localparam logic [2:0] MD_N  = 3'd0;
  localparam logic [2:0] MD_P  = 3'd2;
  localparam logic [2:0] MD_IP = 3'd3;
  localparam logic [2:0] MD_L  = 3'd4;
  localparam logic [2:0] MD_IL = 3'd5;
  localparam logic [2:0] MD_G  = 3'd6;
  localparam logic [2:0] MD_IG = 3'd7;

  localparam logic [1:0] WK_INS = 2'd0;
  localparam logic [1:0] WK_LAB = 2'd1;
  localparam logic [1:0] WK_ENT = 2'd2;
  localparam logic [1:0] WK_END = 2'd3;

  localparam int MaxWords = 5;

  // operator numbers
  localparam logic [6:0] K_CASE = 7'd0,  K_TRUE = 7'd4,  K_FALSE = 7'd5, K_RV = 7'd8;
  localparam logic [6:0] K_FNAP = 7'd10, K_MULT = 7'd11, K_DIV = 7'd12, K_REM = 7'd13;
  localparam logic [6:0] K_PLUS = 7'd14, K_MINUS = 7'd15, K_QUERY = 7'd16, K_NEG = 7'd17;
  localparam logic [6:0] K_EQ = 7'd20, K_NE = 7'd21, K_LS = 7'd22, K_GR = 7'd23;
  localparam logic [6:0] K_LE = 7'd24, K_GE = 7'd25, K_NOT = 7'd30, K_LSH = 7'd31;
  localparam logic [6:0] K_RSH = 7'd32, K_LAND = 7'd33, K_LOR = 7'd34, K_EQV = 7'd35;
  localparam logic [6:0] K_NEQV = 7'd36, K_LP = 7'd40, K_LG = 7'd41, K_LN = 7'd42;
  localparam logic [6:0] K_LL = 7'd44, K_LLP = 7'd45, K_LLG = 7'd46, K_LLL = 7'd47;
  localparam logic [6:0] K_RTAP = 7'd51, K_GOTO = 7'd52, K_FINISH = 7'd68;
  localparam logic [6:0] K_SWITCH = 7'd70, K_GLOBAL = 7'd76, K_SP = 7'd80, K_SG = 7'd81;
  localparam logic [6:0] K_SL = 7'd82, K_STIND = 7'd83, K_JUMP = 7'd85, K_JT = 7'd86;
  localparam logic [6:0] K_JF = 7'd87, K_LAB = 7'd90, K_STACK = 7'd91, K_STORE = 7'd92;
  localparam logic [6:0] K_RSTACK = 7'd93, K_ENTRY = 7'd94, K_SAVE = 7'd95;
  localparam logic [6:0] K_FNRN = 7'd96, K_RTRN = 7'd97, K_RES = 7'd98;

  typedef struct packed {
    logic [1:0]  word_kind;
    logic [3:0]  func;
    logic [2:0]  mode;
    logic [31:0] value;
  } word_t;

  // one translated item: up to five words and a count
  typedef struct packed {
    word_t [MaxWords-1:0] words;
    logic  [2:0]          count;
  } bundle_t;

  typedef struct packed {
    logic [1:0]  cs;
    logic [31:0] sp;
    logic [31:0] pa;
    logic [2:0]  pm;
    logic [31:0] cl;
  } tstate_t;

  function automatic logic [31:0] xcode(input logic [6:0] k);
    logic [31:0] r;
    r = '0;
    unique case (k)
      K_RV:   r = 32'd1;   K_NEG:  r = 32'd2;  K_NOT:  r = 32'd3;
      K_MULT: r = 32'd5;   K_DIV:  r = 32'd6;  K_REM:  r = 32'd7;
      K_MINUS: r = 32'd9;  K_EQ:   r = 32'd10; K_NE:   r = 32'd11;
      K_LS:   r = 32'd12;  K_GE:   r = 32'd13; K_GR:   r = 32'd14;
      K_LE:   r = 32'd15;  K_LSH:  r = 32'd16; K_RSH:  r = 32'd17;
      K_LAND: r = 32'd18;  K_LOR:  r = 32'd19; K_NEQV: r = 32'd20;
      K_EQV:  r = 32'd21;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/stacg_front.sv
// front end: accepts items, updates the cache state and builds the word bundle
module stacg_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [6:0]          in_kind,
  input  logic signed [31:0]  in_operand,
  input  logic signed [31:0]  in_operand_two,
  output logic                q_push,
  output stacg_pkg::bundle_t  q_data,
  input  logic                q_full
);

  logic [15:0]          stack_start_r;
  stacg_pkg::tstate_t   st_r, st_nxt;
  stacg_pkg::bundle_t   bnd;
  logic                 acc;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  // translation of one item
  always_comb begin
    logic [1:0]  cs;
    logic [31:0] sp, pa, a, b;
    logic [2:0]  pm, n;
    stacg_pkg::word_t w;
    cs = st_r.cs; sp = st_r.sp; pa = st_r.pa; pm = st_r.pm;
    a = in_operand; b = in_operand_two;
    n = '0;
    bnd = '0;
    st_nxt = st_r;
    w = '0;
    if (in_kind == stacg_pkg::K_CASE) begin
      if (st_r.cl != '0) begin
        bnd.words[0] = '{stacg_pkg::WK_INS, stacg_pkg::FN_D, stacg_pkg::MD_N, a};
        bnd.words[1] = '{stacg_pkg::WK_INS, stacg_pkg::FN_D, stacg_pkg::MD_L, b};
        n = 3'd2;
        st_nxt.cl = st_r.cl - 32'd1;
      end
    end else begin
      st_nxt.cl = '0;
      unique case (in_kind)
        // loads
        stacg_pkg::K_LP, stacg_pkg::K_LG, stacg_pkg::K_LL, stacg_pkg::K_LN,
        stacg_pkg::K_TRUE, stacg_pkg::K_FALSE, stacg_pkg::K_LLP,
        stacg_pkg::K_LLG, stacg_pkg::K_LLL: begin
          if (cs == stacg_pkg::CS_NIL) cs = stacg_pkg::CS_AD;
          else begin
            if (cs == stacg_pkg::CS_ACAD) begin
              bnd.words[n] = '{stacg_pkg::WK_INS, stacg_pkg::FN_S, stacg_pkg::MD_P,
                               sp - 32'd2}; n = n + 3'd1;
            end
            if (cs != stacg_pkg::CS_AC) begin
              bnd.words[n] = '{stacg_pkg::WK_INS, stacg_pkg::FN_L, pm, pa}; n = n + 3'd1;
            end
            cs = stacg_pkg::CS_ACAD;
          end
          pa = a;
          priority case (in_kind)
            stacg_pkg::K_LP:  pm = stacg_pkg::MD_IP;
            stacg_pkg::K_LG:  pm = stacg_pkg::MD_IG;
            stacg_pkg::K_LL:  pm = stacg_pkg::MD_IL;
            stacg_pkg::K_LLP: pm = stacg_pkg::MD_P;
            stacg_pkg::K_LLG: pm = stacg_pkg::MD_G;
            stacg_pkg::K_LLL: pm = stacg_pkg::MD_L;
            default:          pm = stacg_pkg::MD_N;
          endcase
          if (in_kind == stacg_pkg::K_TRUE) pa = 32'hFFFF_FFFF;
          if (in_kind == stacg_pkg::K_FALSE) pa = '0;
          sp = sp + 32'd1;
        end
        default: ;
      endcase
      // forcing prologues, computed inline for each class of user
      unique case (in_kind)
        // to accumulator users
        stacg_pkg::K_SP, stacg_pkg::K_SG, stacg_pkg::K_SL, stacg_pkg::K_RV,
        stacg_pkg::K_NEG, stacg_pkg::K_NOT, stacg_pkg::K_JT, stacg_pkg::K_JF,
        stacg_pkg::K_RTAP, stacg_pkg::K_FNAP, stacg_pkg::K_FNRN, stacg_pkg::K_RES,
        stacg_pkg::K_SWITCH: begin
          unique case (cs)
            stacg_pkg::CS_NIL: begin
              bnd.words[n] = '{stacg_pkg::WK_INS, stacg_pkg::FN_L, stacg_pkg::MD_IP,
                               sp - 32'd1}; n = n + 3'd1;
            end
            stacg_pkg::CS_ACAD: begin
              bnd.words[n] = '{stacg_pkg::WK_INS, stacg_pkg::FN_S, stacg_pkg::MD_P,
                               sp - 32'd2}; n = n + 3'd1;
              bnd.words[n] = '{stacg_pkg::WK_INS, stacg_pkg::FN_L, pm, pa}; n = n + 3'd1;
            end
            stacg_pkg::CS_AD: begin
              bnd.words[n] = '{stacg_pkg::WK_INS, stacg_pkg::FN_L, pm, pa}; n = n + 3'd1;
            end
            default: ;
          endcase
          cs = stacg_pkg::CS_AC;
        end
        // to accumulator plus address users
        stacg_pkg::K_STIND, stacg_pkg::K_MULT, stacg_pkg::K_DIV, stacg_pkg::K_REM,
        stacg_pkg::K_PLUS, stacg_pkg::K_MINUS, stacg_pkg::K_EQ, stacg_pkg::K_NE,
        stacg_pkg::K_LS, stacg_pkg::K_GR, stacg_pkg::K_LE, stacg_pkg::K_GE,
        stacg_pkg::K_LSH, stacg_pkg::K_RSH, stacg_pkg::K_LAND, stacg_pkg::K_LOR,
        stacg_pkg::K_EQV, stacg_pkg::K_NEQV: begin
          unique case (cs)
            stacg_pkg::CS_AD: begin
              bnd.words[n] = '{stacg_pkg::WK_INS, stacg_pkg::FN_L, stacg_pkg::MD_IP,
                               sp - 32'd2}; n = n + 3'd1;
            end
            stacg_pkg::CS_AC, stacg_pkg::CS_NIL: begin
              if (cs == stacg_pkg::CS_AC) begin
                bnd.words[n] = '{stacg_pkg::WK_INS, stacg_pkg::FN_S, stacg_pkg::MD_P,
                                 sp - 32'd1}; n = n + 3'd1;
              end
              bnd.words[n] = '{stacg_pkg::WK_INS, stacg_pkg::FN_L, stacg_pkg::MD_IP,
                               sp - 32'd2}; n = n + 3'd1;
              pa = sp - 32'd1; pm = stacg_pkg::MD_IP;
            end
            default: ;
          endcase
          cs = stacg_pkg::CS_ACAD;
        end
        // to empty users
        stacg_pkg::K_JUMP, stacg_pkg::K_LAB, stacg_pkg::K_QUERY, stacg_pkg::K_STACK,
        stacg_pkg::K_STORE, stacg_pkg::K_RSTACK: begin
          unique case (cs)
            stacg_pkg::CS_ACAD: begin
              bnd.words[n] = '{stacg_pkg::WK_INS, stacg_pkg::FN_S, stacg_pkg::MD_P,
                               sp - 32'd2}; n = n + 3'd1;
              bnd.words[n] = '{stacg_pkg::WK_INS, stacg_pkg::FN_L, pm, pa}; n = n + 3'd1;
              bnd.words[n] = '{stacg_pkg::WK_INS, stacg_pkg::FN_S, stacg_pkg::MD_P,
                               sp - 32'd1}; n = n + 3'd1;
            end
            stacg_pkg::CS_AD: begin
              bnd.words[n] = '{stacg_pkg::WK_INS, stacg_pkg::FN_L, pm, pa}; n = n + 3'd1;
              bnd.words[n] = '{stacg_pkg::WK_INS, stacg_pkg::FN_S, stacg_pkg::MD_P,
                               sp - 32'd1}; n = n + 3'd1;
            end
            stacg_pkg::CS_AC: begin
              bnd.words[n] = '{stacg_pkg::WK_INS, stacg_pkg::FN_S, stacg_pkg::MD_P,
                               sp - 32'd1}; n = n + 3'd1;
            end
            default: ;
          endcase
          cs = stacg_pkg::CS_NIL;
        end
        // to address user
        stacg_pkg::K_GOTO: begin
          unique case (cs)
            stacg_pkg::CS_ACAD: begin
              bnd.words[n] = '{stacg_pkg::WK_INS, stacg_pkg::FN_S, stacg_pkg::MD_P,
                               sp - 32'd2}; n = n + 3'd1;
            end
            stacg_pkg::CS_AC: begin
              bnd.words[n] = '{stacg_pkg::WK_INS, stacg_pkg::FN_S, stacg_pkg::MD_P,
                               sp - 32'd1}; n = n + 3'd1;
              pa = sp - 32'd1; pm = stacg_pkg::MD_IP;
            end
            stacg_pkg::CS_NIL: begin
              pa = sp - 32'd1; pm = stacg_pkg::MD_IP;
            end
            default: ;
          endcase
          cs = stacg_pkg::CS_AD;
        end
        default: ;
      endcase
      // operation word and state epilogue
      w = '{stacg_pkg::WK_INS, stacg_pkg::FN_X, stacg_pkg::MD_N,
            stacg_pkg::xcode(in_kind)};
      unique case (in_kind)
        stacg_pkg::K_SP, stacg_pkg::K_SG, stacg_pkg::K_SL: begin
          w.func = stacg_pkg::FN_S; w.value = a;
          w.mode = (in_kind == stacg_pkg::K_SP) ? stacg_pkg::MD_P :
                   (in_kind == stacg_pkg::K_SG) ? stacg_pkg::MD_G : stacg_pkg::MD_L;
          bnd.words[n] = w; n = n + 3'd1;
          sp = sp - 32'd1; cs = stacg_pkg::CS_NIL;
        end
        stacg_pkg::K_STIND: begin
          bnd.words[n] = '{stacg_pkg::WK_INS, stacg_pkg::FN_S, pm, pa}; n = n + 3'd1;
          sp = sp - 32'd2; cs = stacg_pkg::CS_NIL;
        end
        stacg_pkg::K_MULT, stacg_pkg::K_DIV, stacg_pkg::K_REM, stacg_pkg::K_MINUS,
        stacg_pkg::K_EQ, stacg_pkg::K_NE, stacg_pkg::K_LS, stacg_pkg::K_GR,
        stacg_pkg::K_LE, stacg_pkg::K_GE, stacg_pkg::K_LSH, stacg_pkg::K_RSH,
        stacg_pkg::K_LAND, stacg_pkg::K_LOR, stacg_pkg::K_EQV, stacg_pkg::K_NEQV: begin
          bnd.words[n] = '{stacg_pkg::WK_INS, stacg_pkg::FN_L, pm, pa}; n = n + 3'd1;
          bnd.words[n] = w; n = n + 3'd1;
          cs = stacg_pkg::CS_AC; sp = sp - 32'd1;
        end
        stacg_pkg::K_RV, stacg_pkg::K_NEG, stacg_pkg::K_NOT: begin
          bnd.words[n] = w; n = n + 3'd1;
        end
        stacg_pkg::K_PLUS: begin
          bnd.words[n] = '{stacg_pkg::WK_INS, stacg_pkg::FN_A, pm, pa}; n = n + 3'd1;
          cs = stacg_pkg::CS_AC; sp = sp - 32'd1;
        end
        stacg_pkg::K_JUMP: begin
          bnd.words[n] = '{stacg_pkg::WK_INS, stacg_pkg::FN_J, stacg_pkg::MD_L, a};
          n = n + 3'd1;
        end
        stacg_pkg::K_JT, stacg_pkg::K_JF: begin
          bnd.words[n] = '{stacg_pkg::WK_INS,
                           (in_kind == stacg_pkg::K_JT) ? stacg_pkg::FN_T : stacg_pkg::FN_F,
                           stacg_pkg::MD_L, a}; n = n + 3'd1;
          sp = sp - 32'd1; cs = stacg_pkg::CS_NIL;
        end
        stacg_pkg::K_GOTO: begin
          bnd.words[n] = '{stacg_pkg::WK_INS, stacg_pkg::FN_J, pm, pa}; n = n + 3'd1;
          sp = sp - 32'd1; cs = stacg_pkg::CS_NIL;
        end
        stacg_pkg::K_LAB: begin
          bnd.words[n] = '{stacg_pkg::WK_LAB, 4'd0, 3'd0, a}; n = n + 3'd1;
        end
        stacg_pkg::K_QUERY: sp = sp + 32'd1;
        stacg_pkg::K_STACK: sp = a;
        stacg_pkg::K_ENTRY: begin
          bnd.words[n] = '{stacg_pkg::WK_ENT, 4'd0, 3'd0, a}; n = n + 3'd1;
        end
        stacg_pkg::K_SAVE: sp = a;
        stacg_pkg::K_RTAP, stacg_pkg::K_FNAP: begin
          bnd.words[n] = '{stacg_pkg::WK_INS, stacg_pkg::FN_K, stacg_pkg::MD_N, a};
          n = n + 3'd1;
          if (in_kind == stacg_pkg::K_FNAP) begin
            sp = a + 32'd1; cs = stacg_pkg::CS_AC;
          end else begin
            sp = a; cs = stacg_pkg::CS_NIL;
          end
        end
        stacg_pkg::K_FNRN, stacg_pkg::K_RTRN: begin
          if (in_kind == stacg_pkg::K_FNRN) sp = sp - 32'd1;
          bnd.words[n] = '{stacg_pkg::WK_INS, stacg_pkg::FN_X, stacg_pkg::MD_N, 32'd4};
          n = n + 3'd1;
          cs = stacg_pkg::CS_NIL;
        end
        stacg_pkg::K_RES: begin
          bnd.words[n] = '{stacg_pkg::WK_INS, stacg_pkg::FN_J, stacg_pkg::MD_L, a};
          n = n + 3'd1;
          sp = sp - 32'd1; cs = stacg_pkg::CS_NIL;
        end
        stacg_pkg::K_RSTACK: begin
          sp = a + 32'd1; cs = stacg_pkg::CS_AC;
        end
        stacg_pkg::K_FINISH: begin
          bnd.words[n] = '{stacg_pkg::WK_INS, stacg_pkg::FN_X, stacg_pkg::MD_N, 32'd22};
          n = n + 3'd1;
        end
        stacg_pkg::K_SWITCH: begin
          bnd.words[n] = '{stacg_pkg::WK_INS, stacg_pkg::FN_X, stacg_pkg::MD_N, 32'd23};
          n = n + 3'd1;
          bnd.words[n] = '{stacg_pkg::WK_INS, stacg_pkg::FN_D, stacg_pkg::MD_N, a};
          n = n + 3'd1;
          bnd.words[n] = '{stacg_pkg::WK_INS, stacg_pkg::FN_D, stacg_pkg::MD_L, b};
          n = n + 3'd1;
          sp = sp - 32'd1; cs = stacg_pkg::CS_NIL;
          st_nxt.cl = a[31] ? '0 : a;
        end
        stacg_pkg::K_GLOBAL: begin
          bnd.words[n] = '{stacg_pkg::WK_END, 4'd0, 3'd0, 32'd0}; n = n + 3'd1;
          sp = {16'd0, stack_start_r}; cs = stacg_pkg::CS_NIL;
        end
        default: ;
      endcase
      st_nxt.cs = cs; st_nxt.sp = sp; st_nxt.pa = pa; st_nxt.pm = pm;
    end
    bnd.count = n;
  end

  assign q_push = acc && (bnd.count != '0);
  assign q_data = bnd;

  // configuration and translator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stack_start_r <= 16'd2;
      st_r          <= '{stacg_pkg::CS_NIL, 32'd2, 32'd0, 3'd0, 32'd0};
    end else begin
      if (cfg_we) stack_start_r <= cfg_data;
      if (acc) st_r <= st_nxt;
    end
  end

endmodule

>>> rtl/stacg_queue.sv
// two-entry queue of word bundles between front and back end
module stacg_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  stacg_pkg::bundle_t wdata,
  output logic               full,
  output logic               not_empty,
  output stacg_pkg::bundle_t rdata,
  input  logic               pop
);

  stacg_pkg::bundle_t mem_r [2];
  logic               wp_r, rp_r;
  logic [1:0]         cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign rdata     = mem_r[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> rtl/stacg_back.sv
// back end: sends the words of one bundle, one per transfer
module stacg_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_not_empty,
  input  stacg_pkg::bundle_t q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_word_kind,
  output logic [3:0]         out_func,
  output logic [2:0]         out_mode,
  output logic signed [31:0] out_value,
  output logic               out_last
);

  logic [2:0]       idx_r;
  stacg_pkg::word_t w;
  logic             lst;

  assign w         = q_data.words[idx_r];
  assign lst       = (idx_r + 3'd1 == q_data.count);
  assign out_valid = q_not_empty;
  assign out_word_kind = w.word_kind;
  assign out_func  = w.func;
  assign out_mode  = w.mode;
  assign out_value = w.value;
  assign out_last  = lst;
  assign q_pop     = out_valid && out_ready && lst;

  // word index within the bundle
  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= '0;
    else if (out_valid && out_ready) idx_r <= lst ? 3'd0 : idx_r + 3'd1;
  end

endmodule

>>> rtl/stack_to_accumulator_code_gen.sv
// top level of the stack-code to accumulator-code translator
// Each input item is translated in the cycle it is accepted into a bundle of zero to
// five words, which is queued (two bundles deep); the output side then sends one word
// per transfer, last set on the final word. The input takes a new item whenever the
// queue is not full; out_ready stalls the output. Items emitting nothing leave no trace
// in the queue. stack_start is to be written only idle; the block does not enforce it.
module stack_to_accumulator_code_gen (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_stack_start,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [6:0]         in_kind,
  input  logic signed [31:0] in_operand,
  input  logic signed [31:0] in_operand_two,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_word_kind,
  output logic [3:0]         out_func,
  output logic [2:0]         out_mode,
  output logic signed [31:0] out_value,
  output logic               out_last
);

  logic               q_push, q_full, q_ne, q_pop;
  stacg_pkg::bundle_t q_wdata, q_rdata;

  stacg_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_data(cfg_stack_start), .in_valid, .in_ready,
    .in_kind, .in_operand, .in_operand_two, .q_push, .q_data(q_wdata), .q_full
  );

  stacg_queue u_queue (
    .clk, .rst_n, .push(q_push), .wdata(q_wdata), .full(q_full),
    .not_empty(q_ne), .rdata(q_rdata), .pop(q_pop)
  );

  stacg_back u_back (
    .clk, .rst_n, .q_not_empty(q_ne), .q_data(q_rdata), .q_pop, .out_valid,
    .out_ready, .out_word_kind, .out_func, .out_mode, .out_value, .out_last
  );

  // checks
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push) else $error("push into full queue");
  a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_ne) else $error("pop from empty queue");
  a_bundle_count: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_wdata.count != 3'd0 && q_wdata.count <= 3'd5))
    else $error("bad bundle size");

endmodule
